>>> hw/rtl/xcs_pkg.sv
// Shared types, constants and the Hamming check function for the XOR-16 checksum block.
package xcs_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned FrameW = 16;
  localparam int unsigned HamLen = 21;
  localparam int unsigned CodeW  = 5;

  // Hamming position (1-based) of each data bit, LSB first
  localparam logic [4:0] DATA_POS [WordW] = '{
    5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd10, 5'd11, 5'd12,
    5'd13, 5'd14, 5'd15, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21
  };

  // Finished word handed from the fold stage to the output stage
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] word;
  } word_stage_t;

  // Even parity p1,p2,p4,p8,p16 over the data bits placed in the Hamming word
  function automatic logic [CodeW-1:0] hamming_checks(input logic [WordW-1:0] word);
    logic [CodeW-1:0] code;
    code = '0;
    for (int k = 0; k < CodeW; k++) begin
      for (int b = 0; b < WordW; b++) begin
        if (DATA_POS[b][k]) begin
          code[k] = code[k] ^ word[b];
        end
      end
    end
    return code;
  endfunction

endpackage

>>> hw/rtl/xcs_fold.sv
// Byte fold stage: running XOR accumulator, byte counter and final word register.
module xcs_fold (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [xcs_pkg::DataW-1:0]     data_byte,
  input  logic                          is_last,
  input  logic [xcs_pkg::FrameW-1:0]    frame_number,
  input  logic                          is_start,
  input  logic                          is_end,
  input  logic                          take,
  output xcs_pkg::word_stage_t          stage
);

  logic [xcs_pkg::WordW-1:0] fold_word;
  logic [xcs_pkg::WordW-1:0] byte_count;
  logic [xcs_pkg::WordW-1:0] fold_next;
  logic [xcs_pkg::WordW-1:0] count_next;
  logic [xcs_pkg::WordW-1:0] word_next;
  logic                      valid;
  logic [xcs_pkg::WordW-1:0] word;

  // Fold the byte into its lane, count it and form the closing word
  always_comb begin
    if (byte_count[0]) begin
      fold_next = fold_word ^ {{(xcs_pkg::WordW-xcs_pkg::DataW){1'b0}}, data_byte};
    end else begin
      fold_next = fold_word ^ {data_byte, {(xcs_pkg::WordW-xcs_pkg::DataW){1'b0}}};
    end
    count_next = byte_count + {{(xcs_pkg::WordW-1){1'b0}}, 1'b1};
    word_next  = fold_next ^ count_next ^ frame_number
               ^ {{(xcs_pkg::WordW-2){1'b0}}, is_start, is_end};
  end

  // Advance the accumulator; clear it when the frame closes
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_word  <= '0;
      byte_count <= '0;
    end else if (accept) begin
      if (is_last) begin
        fold_word  <= '0;
        byte_count <= '0;
      end else begin
        fold_word  <= fold_next;
        byte_count <= count_next;
      end
    end
  end

  // Hold the closing word until the output stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept && is_last) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_last) begin
      word <= word_next;
    end
  end

  assign stage.valid = valid;
  assign stage.word  = word;

endmodule

>>> hw/rtl/xcs_code.sv
// Output stage: Hamming parity of the closing word into the result register.
module xcs_code (
  input  logic                          clk,
  input  logic                          rst,
  input  xcs_pkg::word_stage_t          stage,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [xcs_pkg::CodeW-1:0]     check_code
);

  logic                      valid;
  logic [xcs_pkg::CodeW-1:0] code;
  logic                      room;

  // Load when the register is empty or its item leaves this cycle
  assign room = !valid || out_ready;
  assign take = stage.valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room) begin
      valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code <= xcs_pkg::hamming_checks(stage.word);
    end
  end

  assign out_valid  = valid;
  assign check_code = code;

endmodule

>>> hw/rtl/xor_checksum_hamming_parity.sv
// Top level of the XOR-16 frame checksum with Hamming(21,16) check code.
//
// Input channel (in_valid/in_ready): one payload byte per item, with is_last
// marking the final byte of a frame; frame_number, is_start and is_end are
// used only on that last byte. Output channel (out_valid/out_ready): one
// item per frame carrying the five check bits, bit0=p1 up to bit4=p16.
// Throughput: one byte per cycle while in_ready is high. The fold accumulator
// updates in the cycle a byte is taken; the closing word lands in a word
// register and its parity is then registered in the result register, from
// which check_code shows.
// Stalls: while the receiver holds out_ready low the result stays put and
// the word register can still fill; in_ready drops only once both are full.
// Reset (rst, synchronous): accumulator and byte count clear, both stages
// empty; the block takes bytes in the first cycle after reset.
module xor_checksum_hamming_parity (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [xcs_pkg::DataW-1:0]     data_byte,
  input  logic                          is_last,
  input  logic [xcs_pkg::FrameW-1:0]    frame_number,
  input  logic                          is_start,
  input  logic                          is_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [xcs_pkg::CodeW-1:0]     check_code
);

  xcs_pkg::word_stage_t stage;
  logic                 take;
  logic                 accept;

  // Take a byte whenever the word register is free or drains this cycle
  assign in_ready = !stage.valid || take;
  assign accept   = in_valid && in_ready;

  xcs_fold u_fold (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .is_last      (is_last),
    .frame_number (frame_number),
    .is_start     (is_start),
    .is_end       (is_end),
    .take         (take),
    .stage        (stage)
  );

  xcs_code u_code (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .check_code (check_code)
  );

endmodule

>>> hw/rtl/xcs_checker.sv
// Port-level checks for the checksum block, bound to its top level.
module xcs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      is_last,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [xcs_pkg::CodeW-1:0] check_code
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(check_code))
    else $error("stalled result changed");

  // Input backpressure only when a result is waiting and stalled
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without an output stall");

  // A last byte taken into an empty block shows a result once it has passed the word and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && is_last && !out_valid && in_ready
      ##0 $past(!out_valid) |-> ##2 out_valid)
    else $error("result missing two cycles after last byte");

endmodule

bind xor_checksum_hamming_parity xcs_checker u_xcs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .is_last    (is_last),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .check_code (check_code)
);

>>> tb/xor_checksum_hamming_parity_checker.sv
// Checker that predicts the Hamming check code of each frame and compares it with the block's output.
`timescale 1ns / 1ps

module xor_checksum_hamming_parity_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [xcs_pkg::DataW-1:0]  data_byte,
  input  logic                       is_last,
  input  logic [xcs_pkg::FrameW-1:0] frame_number,
  input  logic                       is_start,
  input  logic                       is_end,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [xcs_pkg::CodeW-1:0]  check_code,
  output int                         mismatch_count,
  output int                         codes_pending
);

  // Running copy of the block's frame state
  logic [xcs_pkg::WordW-1:0] fold_acc;
  logic [xcs_pkg::WordW-1:0] byte_cnt;
  logic [xcs_pkg::WordW-1:0] closing_word;
  logic [xcs_pkg::CodeW-1:0] want_code;

  // Check codes of closed frames, oldest first
  logic [xcs_pkg::CodeW-1:0] expected_codes[$];

  // Spread the word over the non-power-of-two positions 3..21, LSB first,
  // then take even parity over each position bit
  function automatic logic [xcs_pkg::CodeW-1:0] parity_of_word(
      input logic [xcs_pkg::WordW-1:0] word);
    logic [xcs_pkg::CodeW-1:0] code;
    int                        bit_idx;
    code    = '0;
    bit_idx = 0;
    for (int pos = 1; pos <= xcs_pkg::HamLen; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        for (int k = 0; k < xcs_pkg::CodeW; k++) begin
          if (((pos >> k) & 1) != 0) begin
            code[k] = code[k] ^ word[bit_idx];
          end
        end
        bit_idx++;
      end
    end
    return code;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fold_acc       = '0;
      byte_cnt       = '0;
      mismatch_count = 0;
      expected_codes.delete();
    end else begin
      // Fold the accepted byte into the lane picked by the count's low bit
      if (in_valid && in_ready) begin
        if (byte_cnt[0] == 1'b0) begin
          fold_acc = fold_acc ^ {data_byte, 8'h00};
        end else begin
          fold_acc = fold_acc ^ {8'h00, data_byte};
        end
        byte_cnt = byte_cnt + 16'd1;
        // Close the frame: mix in count, frame number and flags
        if (is_last) begin
          closing_word = fold_acc ^ byte_cnt ^ frame_number ^ {14'd0, is_start, is_end};
          expected_codes = {expected_codes, parity_of_word(closing_word)};
          fold_acc = '0;
          byte_cnt = '0;
        end
      end
      // Compare each delivered code with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: check_code %0h delivered with no frame closed", $realtime,
                     check_code);
          end
          mismatch_count++;
        end else begin
          want_code = expected_codes.pop_front();
          if (check_code !== want_code) begin
            if (mismatch_count < 10) begin
              $display("%0t: check_code expected %02h actual %02h", $realtime, want_code,
                       check_code);
            end
            mismatch_count++;
          end
        end
      end
    end
    codes_pending <= expected_codes.size();
  end

endmodule

>>> tb/xor_checksum_hamming_parity_tb.sv
// Top of the testbench: drives frames of payload bytes into the checksum block and gives the verdict.
`timescale 1ns / 1ps

module xor_checksum_hamming_parity_tb;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 150;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       in_valid     = 1'b0;
  logic                       in_ready;
  logic [xcs_pkg::DataW-1:0]  data_byte    = '0;
  logic                       is_last      = 1'b0;
  logic [xcs_pkg::FrameW-1:0] frame_number = '0;
  logic                       is_start     = 1'b0;
  logic                       is_end       = 1'b0;
  logic                       out_valid;
  logic                       out_ready    = 1'b0;
  logic [xcs_pkg::CodeW-1:0]  check_code;

  int mismatch_count;
  int codes_pending;
  int bytes_sent;
  bit idle_on   = 1'b0;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;

  xor_checksum_hamming_parity i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .is_last      (is_last),
    .frame_number (frame_number),
    .is_start     (is_start),
    .is_end       (is_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .check_code   (check_code)
  );

  xor_checksum_hamming_parity_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .is_last        (is_last),
    .frame_number   (frame_number),
    .is_start       (is_start),
    .is_end         (is_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .check_code     (check_code),
    .mismatch_count (mismatch_count),
    .codes_pending  (codes_pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Give up after a generous number of cycles
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Offer one byte, with an optional idle burst first, and hold it until taken
  task automatic send_byte(input logic [xcs_pkg::DataW-1:0] b, input logic last,
                           input logic [xcs_pkg::FrameW-1:0] fnum, input logic st,
                           input logic en);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    is_last      <= last;
    frame_number <= fnum;
    is_start     <= st;
    is_end       <= en;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send a frame of random bytes; flags and frame number are random on every byte
  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), (i == len - 1), 16'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Pick a frame length: mostly short, sometimes medium, rarely a few hundred
  function automatic int pick_frame_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return $urandom_range(1, 6);
    end else if (roll < 95) begin
      return $urandom_range(7, 40);
    end
    return $urandom_range(41, 300);
  endfunction

  // Stop offering and let every outstanding code come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (codes_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: random back-pressure bursts and one long hold-off on request
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Sender: directed frames, back-pressure, random frames
  initial begin
    bytes_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // One-byte frames at the field extremes and every flag combination
    send_byte(8'hFF, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 16'h0000, 1'b0, 1'b0);
    send_byte(8'h80, 1'b1, 16'h8000, 1'b1, 1'b0);
    send_byte(8'h01, 1'b1, 16'h0001, 1'b0, 1'b1);
    // Two-byte frame: ignored fields set on the first byte
    send_byte(8'hA5, 1'b0, 16'hFFFF, 1'b1, 1'b1);
    send_byte(8'h5A, 1'b1, 16'h1234, 1'b0, 1'b0);
    // Three-byte frame: same byte lands in both lanes and cancels in the high one
    send_byte(8'hFF, 1'b0, 16'h0000, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 16'hFFFF, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    // Walking ones over four and five bytes
    send_byte(8'h01, 1'b0, 16'h0000, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 16'h0000, 1'b0, 1'b0);
    send_byte(8'h04, 1'b0, 16'h0000, 1'b0, 1'b0);
    send_byte(8'h08, 1'b1, 16'hAAAA, 1'b1, 1'b0);
    send_byte(8'h10, 1'b0, 16'h0000, 1'b0, 1'b0);
    send_byte(8'h20, 1'b0, 16'h0000, 1'b0, 1'b0);
    send_byte(8'h40, 1'b0, 16'h0000, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 16'h0000, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 16'h5555, 1'b0, 1'b1);

    // Fill the block while the receiver holds off
    long_hold = 1'b1;
    for (int i = 0; i < 10; i++) begin
      send_frame(1);
    end

    // Pause until every code has come back
    wait_drained();

    // Random frames with idling on both sides, switched off now and then
    while (bytes_sent < 1500) begin
      if ($urandom_range(0, 15) == 0) begin
        idle_on = !idle_on;
      end
      send_frame(pick_frame_len());
    end

    // Closing stretch at full rate
    idle_on = 1'b0;
    while (bytes_sent < 1750) begin
      send_frame(pick_frame_len());
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/xcs_pkg.sv
hw/rtl/xcs_fold.sv
hw/rtl/xcs_code.sv
hw/rtl/xor_checksum_hamming_parity.sv
hw/rtl/xcs_checker.sv
tb/xor_checksum_hamming_parity_checker.sv
tb/xor_checksum_hamming_parity_tb.sv
